// ----- hdl/longest_palindrome_finder_core_macros.svh -----
// Assertion helpers for the palindrome finder
`ifndef LONGEST_PALINDROME_FINDER_CORE_MACROS_SVH
`define LONGEST_PALINDROME_FINDER_CORE_MACROS_SVH

// same-cycle implication
`define LPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpf: same-cycle check failed");

// next-cycle implication
`define LPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpf: next-cycle check failed");

`endif

// ----- hdl/lpf_pkg.sv -----
package lpf_pkg;

    localparam int MAX_CHARS_DEF = 1024;
    localparam int CHAR_W        = 8;
    localparam int START_W       = 10;
    localparam int LEN_W         = 11;

    typedef struct packed {
        logic load;
        logic search_init;
        logic pass_init;
        logic gap;
        logic rd_rad;
        logic set_k;
        logic rd_text;
        logic inc_k;
        logic commit;
        logic clear;
    } lpf_cmd_t;

    typedef struct packed {
        logic i_done;
        logic bound_ok;
        logic match;
    } lpf_sts_t;

endpackage

// ----- hdl/lpf_in_if.sv -----
interface lpf_in_if;
    import lpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              last;

    modport source (output valid, output char_in, output last, input ready);
    modport sink   (input valid, input char_in, input last, output ready);
endinterface

// ----- hdl/lpf_out_if.sv -----
interface lpf_out_if;
    import lpf_pkg::*;

    logic               valid;
    logic               ready;
    logic [START_W-1:0] start_index;
    logic [LEN_W-1:0]   pal_length;
    logic               overflow;

    modport source (output valid, output start_index, output pal_length, output overflow,
                    input ready);
    modport sink   (input valid, input start_index, input pal_length, input overflow,
                    output ready);
endinterface

// ----- hdl/lpf_ram.sv -----
module lpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- hdl/lpf_datapath.sv -----
module lpf_datapath #(
    parameter int MAX_CHARS = lpf_pkg::MAX_CHARS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lpf_pkg::lpf_cmd_t            cmd,
    output lpf_pkg::lpf_sts_t            sts,
    input  logic [lpf_pkg::CHAR_W-1:0]   char_in,
    output logic [lpf_pkg::START_W-1:0]  start_index,
    output logic [lpf_pkg::LEN_W-1:0]    pal_length,
    output logic                         overflow
);
    import lpf_pkg::*;

    localparam int AW = $clog2(MAX_CHARS);
    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;
    localparam int XW = (AW > START_W) ? AW : START_W;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] rc_reg, rc_next;
    logic [AW-1:0] rr_reg, rr_next;
    logic [AW-1:0] best_start_reg, best_start_next;
    logic [CW-1:0] best_len_reg, best_len_next;

    logic [SW-1:0] n_ext, i_ext, k_ext, gap_ext;
    logic [SW-1:0] reach, lim, m_full, pass_cnt, hi, lo, len, bstart;
    logic          in_reach, full, better, extend;
    logic [AW-1:0] k_set;

    logic [CHAR_W-1:0] text_lo_q, text_hi_q;
    logic [AW-1:0]     rad_q;
    logic              text_we;

    logic [LW-1:0] len_wide;
    logic [XW-1:0] start_wide;

    assign n_ext    = SW'(count_reg);
    assign i_ext    = SW'(i_reg);
    assign k_ext    = SW'(k_reg);
    assign gap_ext  = SW'(cmd.gap);
    assign reach    = SW'(rc_reg) + SW'(rr_reg);
    assign in_reach = i_ext < reach;
    assign lim      = reach - i_ext;
    assign m_full   = (SW'(rc_reg) << 1) - i_ext;
    assign pass_cnt = n_ext - gap_ext;
    assign hi       = i_ext + k_ext + SW'(1);
    assign lo       = i_ext + gap_ext - k_ext - SW'(1);
    assign len      = (k_ext << 1) + SW'(1) - gap_ext;
    assign bstart   = i_ext - k_ext + gap_ext;
    assign better   = len > SW'(best_len_reg);
    assign extend   = (i_ext + k_ext) > reach;
    assign full     = count_reg == CW'(MAX_CHARS);
    assign text_we  = cmd.load && !full;

    assign k_set = !in_reach ? '0 : ((SW'(rad_q) < lim) ? rad_q : lim[AW-1:0]);

    assign sts.i_done   = i_ext >= pass_cnt;
    assign sts.bound_ok = (i_ext + gap_ext > k_ext) && (hi < n_ext);
    assign sts.match    = text_lo_q == text_hi_q;

    lpf_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_CHARS)) u_text_lo (
        .clk   (clk),
        .we    (text_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (char_in),
        .re    (cmd.rd_text),
        .raddr (lo[AW-1:0]),
        .rdata (text_lo_q)
    );

    lpf_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_CHARS)) u_text_hi (
        .clk   (clk),
        .we    (text_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (char_in),
        .re    (cmd.rd_text),
        .raddr (hi[AW-1:0]),
        .rdata (text_hi_q)
    );

    lpf_ram #(.WIDTH(AW), .DEPTH(MAX_CHARS)) u_radius (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (i_reg[AW-1:0]),
        .wdata (k_reg),
        .re    (cmd.rd_rad),
        .raddr (m_full[AW-1:0]),
        .rdata (rad_q)
    );

    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        rc_next         = rc_reg;
        rr_next         = rr_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;

        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        if (cmd.search_init)
        begin
            best_start_next = '0;
            best_len_next   = CW'(1);
        end
        if (cmd.pass_init)
        begin
            i_next  = '0;
            rc_next = '0;
            rr_next = '0;
        end
        if (cmd.set_k)
        begin
            k_next = k_set;
        end
        if (cmd.inc_k)
        begin
            k_next = k_reg + AW'(1);
        end
        if (cmd.commit)
        begin
            i_next = i_reg + CW'(1);
            if (better)
            begin
                best_len_next   = len[CW-1:0];
                best_start_next = bstart[AW-1:0];
            end
            if (extend)
            begin
                rc_next = i_reg[AW-1:0];
                rr_next = k_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            k_reg          <= '0;
            rc_reg         <= '0;
            rr_reg         <= '0;
            best_start_reg <= '0;
            best_len_reg   <= CW'(1);
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            rc_reg         <= rc_next;
            rr_reg         <= rr_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
        end
    end

    assign len_wide    = LW'(best_len_reg);
    assign start_wide  = XW'(best_start_reg);
    assign pal_length  = len_wide[LEN_W-1:0];
    assign start_index = start_wide[START_W-1:0];
    assign overflow    = ovf_reg;
endmodule

// ----- hdl/lpf_ctrl.sv -----
module lpf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lpf_pkg::lpf_sts_t sts,
    output lpf_pkg::lpf_cmd_t cmd
);
    import lpf_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_CENTER,
        S_RADIUS,
        S_EXT,
        S_CMP,
        S_COMMIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   gap_reg, gap_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.gap    = gap_reg;
        state_next = state_reg;
        gap_next   = gap_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.search_init = 1'b1;
                        gap_next        = 1'b0;
                        state_next      = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                cmd.pass_init = 1'b1;
                state_next    = S_CENTER;
            end
            S_CENTER:
            begin
                if (sts.i_done)
                begin
                    if (!gap_reg)
                    begin
                        gap_next   = 1'b1;
                        state_next = S_PASS;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cmd.rd_rad = 1'b1;
                    state_next = S_RADIUS;
                end
            end
            S_RADIUS:
            begin
                cmd.set_k  = 1'b1;
                state_next = S_EXT;
            end
            S_EXT:
            begin
                if (sts.bound_ok)
                begin
                    cmd.rd_text = 1'b1;
                    state_next  = S_CMP;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_CMP:
            begin
                if (sts.match)
                begin
                    cmd.inc_k  = 1'b1;
                    state_next = S_EXT;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_CENTER;
            end
            S_OUT:
            begin
                if (out_valid_reg && out_ready)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        in_ready_next  = state_next == S_LOAD;
        out_valid_next = state_next == S_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            gap_reg       <= 1'b0;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gap_reg       <= gap_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
endmodule

// ----- hdl/longest_palindrome_finder_core.sv -----
// channel   dir  fields                               word
// text_in   in   char_in[7:0], last                   one character, last ends string
// result    out  start_index[9:0], pal_length[10:0],  one per string
//                overflow
//
// Loading accepts a word whenever one is offered; text_in is ready only while loading.
// After the last word: two passes (odd, then even centers), each with a setup state, then
// per center a radius read, a radius set, then bound checks and text RAM compares until
// growth stops at a string end or mismatch, then a commit; a closing check ends a pass.
// The result word holds until taken; the next string is taken after that.
// Reset is asynchronous; text and radius RAMs need no clearing after reset.
`include "longest_palindrome_finder_core_macros.svh"

module longest_palindrome_finder_core #(
    parameter int MAX_CHARS = lpf_pkg::MAX_CHARS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    lpf_in_if.sink    text_in,
    lpf_out_if.source result
);
    import lpf_pkg::*;

    lpf_cmd_t cmd;
    lpf_sts_t sts;

    lpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (text_in.valid),
        .in_last   (text_in.last),
        .in_ready  (text_in.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lpf_datapath #(.MAX_CHARS(MAX_CHARS)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .char_in     (text_in.char_in),
        .start_index (result.start_index),
        .pal_length  (result.pal_length),
        .overflow    (result.overflow)
    );

    `LPF_ASSERT_SAME(a_in_out_excl, clk, rst_n, result.valid, !text_in.ready)
    `LPF_ASSERT_NEXT(a_out_once, clk, rst_n, result.valid && result.ready, !result.valid)
    `LPF_ASSERT_SAME(a_read_in_bounds, clk, rst_n, cmd.rd_text, sts.bound_ok)
    `LPF_ASSERT_SAME(a_inc_after_read, clk, rst_n, cmd.inc_k, $past(cmd.rd_text))
endmodule

// ----- dv/tb_longest_palindrome_finder_core.sv -----
module tb_longest_palindrome_finder_core;
    import lpf_pkg::*;

    localparam int CAP         = MAX_CHARS_DEF;
    localparam int QUIET_LIMIT = 60000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_WORDS  = 900;

    typedef struct packed {
        logic [START_W-1:0] start_index;
        logic [LEN_W-1:0]   pal_length;
        logic               overflow;
    } pal_result_t;

    typedef struct packed {
        logic        known;
        pal_result_t value;
    } answer_t;

    typedef struct {
        string             txt;
        int                fill_len;
        logic [CHAR_W-1:0] fill_char;
        logic              known;
        int                e_start;
        int                e_len;
        logic              e_ovf;
    } probe_row_t;

    // txt, then fill_len copies of fill_char; expected values only where obvious
    probe_row_t directed_rows [12] = '{
        '{"",        1, 8'h00, 1'b1, 0, 1,    1'b0},
        '{"",        2, 8'hFF, 1'b1, 0, 2,    1'b0},
        '{"ab",      0, 8'h00, 1'b1, 0, 1,    1'b0},
        '{"aba",     0, 8'h00, 1'b1, 0, 3,    1'b0},
        '{"abba",    0, 8'h00, 1'b1, 0, 4,    1'b0},
        '{"xabay",   0, 8'h00, 1'b0, 0, 0,    1'b0},
        '{"abab",    0, 8'h00, 1'b0, 0, 0,    1'b0},
        '{"aabb",    0, 8'h00, 1'b0, 0, 0,    1'b0},
        '{"abaxyyx", 0, 8'h00, 1'b0, 0, 0,    1'b0},
        '{"",     1024, 8'h71, 1'b1, 0, 1024, 1'b0},
        '{"",     1030, 8'h72, 1'b1, 0, 1024, 1'b1},
        '{"cc",      0, 8'h00, 1'b1, 0, 2,    1'b0}
    };

    logic clk;
    logic rst_n;

    lpf_in_if  text_ch ();
    lpf_out_if result_ch ();

    longest_palindrome_finder_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text_in(text_ch),
        .result (result_ch)
    );

    // predictor state
    logic [CHAR_W-1:0] text_mem [CAP];
    int                radius_mem [CAP];
    int                held_chars;
    logic              dropped;
    int                best_start;
    int                best_len;

    pal_result_t       pending_results[$];
    answer_t           typed_answers[$];
    logic [CHAR_W-1:0] word_buf[$];

    int   src_idle_pct;
    int   snk_idle_pct;
    bit   hold_req;
    int   hold_left;
    int   quiet_cycles;
    bit   stalled_out;
    int   fault_count;
    int   results_seen;
    int   words_accepted;
    int   strings_sent;
    int   longest_text;
    int   overflow_seen;
    int   longest_pal;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic void scan_centers(input int n, input int gap);
        int c;
        int r;
        int k;
        int m;
        int lim;
        int mr;
        int lo;
        int hi;
        int span;
        c = 0;
        r = 0;
        for (int i = 0; i < n - gap; i++)
        begin
            k = 0;
            if (i < c + r)
            begin
                m   = 2 * c - i;
                lim = c + r - i;
                mr  = (m >= 0 && m < CAP) ? radius_mem[m] : 0;
                k   = (mr < lim) ? mr : lim;
            end
            lo = i - k - 1 + gap;
            hi = i + k + 1;
            while (lo >= 0 && hi < n && text_mem[lo] == text_mem[hi])
            begin
                k++;
                lo--;
                hi++;
            end
            radius_mem[i] = k;
            span = 2 * k + 1 - gap;
            if (span > best_len)
            begin
                best_len   = span;
                best_start = i - k + gap;
            end
            if (i + k > c + r)
            begin
                c = i;
                r = k;
            end
        end
    endfunction

    function automatic bit absorb_char(input logic [CHAR_W-1:0] ch, input logic lst,
                                       output pal_result_t res);
        res = '0;
        if (held_chars < CAP)
        begin
            text_mem[held_chars] = ch;
            held_chars++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (!lst)
            return 1'b0;
        best_start = 0;
        best_len   = 1;
        scan_centers(held_chars, 0);
        scan_centers(held_chars, 1);
        res.start_index = best_start[START_W-1:0];
        res.pal_length  = best_len[LEN_W-1:0];
        res.overflow    = dropped;
        held_chars = 0;
        dropped    = 1'b0;
        return 1'b1;
    endfunction

    // input side: run the predictor on every accepted word
    always @(posedge clk)
    begin
        pal_result_t res;
        answer_t     ans;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            words_accepted++;
            if (absorb_char(text_ch.char_in, text_ch.last, res))
            begin
                ans = typed_answers.pop_front();
                pending_results.push_back(ans.known ? ans.value : res);
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        pal_result_t got;
        pal_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.start_index = result_ch.start_index;
            got.pal_length  = result_ch.pal_length;
            got.overflow    = result_ch.overflow;
            results_seen++;
            if (int'(got.pal_length) > longest_pal)
                longest_pal = int'(got.pal_length);
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("ERROR: result start=%0d len=%0d ovf=%0b with none outstanding",
                             got.start_index, got.pal_length, got.overflow);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.start_index !== want.start_index || got.pal_length !== want.pal_length
                    || got.overflow !== want.overflow)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("ERROR: #%0d start/len/ovf exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 results_seen, want.start_index, want.pal_length,
                                 want.overflow, got.start_index, got.pal_length,
                                 got.overflow);
                end
            end
        end
    end

    // receiver
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
            stalled_out = 1'b1;
    end

    task automatic send_word(input logic [CHAR_W-1:0] ch, input logic lst);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.char_in <= ch;
        text_ch.last    <= lst;
        do
            @(posedge clk);
        while (!text_ch.ready);
    endtask

    task automatic send_text(input answer_t ans);
        typed_answers.push_back(ans);
        for (int j = 0; j < word_buf.size(); j++)
            send_word(word_buf[j], j == word_buf.size() - 1);
        strings_sent++;
        if (word_buf.size() > longest_text)
            longest_text = word_buf.size();
        if (word_buf.size() > CAP)
            overflow_seen++;
    endtask

    task automatic make_random_text();
        logic [CHAR_W-1:0] half[$];
        logic [CHAR_W-1:0] base;
        int                kind;
        int                nsym;
        int                len;
        word_buf.delete();
        kind = $urandom_range(99);
        base = CHAR_W'($urandom_range(255));
        nsym = $urandom_range(2, 3);
        if (kind < 45)
        begin
            len = $urandom_range(1, 12);
            repeat (len) word_buf.push_back(CHAR_W'(base + $urandom_range(nsym - 1)));
        end
        else if (kind < 75)
        begin
            repeat ($urandom_range(4)) word_buf.push_back(CHAR_W'($urandom_range(255)));
            repeat ($urandom_range(1, 6)) half.push_back(CHAR_W'(base + $urandom_range(nsym - 1)));
            foreach (half[j]) word_buf.push_back(half[j]);
            if ($urandom_range(1))
                word_buf.push_back(CHAR_W'($urandom_range(255)));
            for (int j = half.size() - 1; j >= 0; j--)
                word_buf.push_back(half[j]);
            repeat ($urandom_range(4)) word_buf.push_back(CHAR_W'($urandom_range(255)));
        end
        else if (kind < 97)
        begin
            len = $urandom_range(1, 8);
            repeat (len) word_buf.push_back(CHAR_W'($urandom_range(255)));
        end
        else
        begin
            len = $urandom_range(40, 150);
            repeat (len) word_buf.push_back(CHAR_W'(base + $urandom_range(1)));
        end
    endtask

    task automatic run_stimulus();
        answer_t ans;
        int      rand_words;
        bit      pressed;
        src_idle_pct = 35;
        snk_idle_pct = 54;
        foreach (directed_rows[r])
        begin
            word_buf.delete();
            for (int j = 0; j < directed_rows[r].txt.len(); j++)
                word_buf.push_back(directed_rows[r].txt[j]);
            repeat (directed_rows[r].fill_len) word_buf.push_back(directed_rows[r].fill_char);
            ans.known             = directed_rows[r].known;
            ans.value.start_index = START_W'(directed_rows[r].e_start);
            ans.value.pal_length  = LEN_W'(directed_rows[r].e_len);
            ans.value.overflow    = directed_rows[r].e_ovf;
            send_text(ans);
        end
        rand_words = 0;
        pressed    = 1'b0;
        while (rand_words < RAND_WORDS)
        begin
            if (rand_words < 300)
            begin
                src_idle_pct = 35;
                snk_idle_pct = 54;
            end
            else if (rand_words < 600)
            begin
                src_idle_pct = 54;
                snk_idle_pct = 35;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // long receiver hold-off: result backs up, input stalls
            if (!pressed && rand_words >= 650)
            begin
                hold_req = 1'b1;
                pressed  = 1'b1;
            end
            make_random_text();
            send_text('0);
            rand_words += word_buf.size();
        end
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        text_ch.valid   = 1'b0;
        text_ch.char_in = '0;
        text_ch.last    = 1'b0;
        held_chars      = 0;
        dropped         = 1'b0;
        hold_req        = 1'b0;
        hold_left       = 0;
        quiet_cycles    = 0;
        stalled_out     = 1'b0;
        fault_count     = 0;
        results_seen    = 0;
        words_accepted  = 0;
        strings_sent    = 0;
        longest_text    = 0;
        overflow_seen   = 0;
        longest_pal     = 0;
        src_idle_pct    = 35;
        snk_idle_pct    = 54;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        fork
            run_stimulus();
            wait (stalled_out);
        join_any
        disable fork;
        if (stalled_out)
            $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, pending_results.size());
        $display("Sent %0d strings (%0d characters accepted, longest %0d, %0d over capacity).",
                 strings_sent, words_accepted, longest_text, overflow_seen);
        $display("Checked %0d results, longest palindrome reported %0d, %0d mismatches.",
                 results_seen, longest_pal, fault_count);
        if (!stalled_out && fault_count == 0 && pending_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/lpf_pkg.sv
hdl/lpf_in_if.sv
hdl/lpf_out_if.sv
hdl/lpf_ram.sv
hdl/lpf_datapath.sv
hdl/lpf_ctrl.sv
hdl/longest_palindrome_finder_core.sv
dv/tb_longest_palindrome_finder_core.sv
